// ===== hdl/slsc_pkg.sv =====
// Shared constants and register index codes for the staircase light switch controller.
`timescale 1ns / 1ps

package slsc_pkg;

  localparam int unsigned TICK_W   = 8;   // debounce counter width
  localparam int unsigned TIMER_W  = 16;  // auto-off countdown width
  localparam int unsigned LEVEL_W  = 4;   // PWM phase and LED level width
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [TICK_W-1:0]  FILTER_COUNT_RST   = 8'd10;
  localparam logic [TICK_W-1:0]  FILTER_LIMIT_RST   = 8'd100;
  localparam logic [TIMER_W-1:0] AUTO_OFF_TICKS_RST = 16'd30000;
  localparam logic [LEVEL_W-1:0] PWM_STEPS_RST      = 4'd5;
  localparam logic               DOOR_ENABLE_RST    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_COUNT   = 3'd0,
    REG_FILTER_LIMIT   = 3'd1,
    REG_AUTO_OFF_TICKS = 3'd2,
    REG_PWM_STEPS      = 3'd3,
    REG_DOOR_ENABLE    = 3'd4
  } cfg_reg_t;

endpackage

// ===== hdl/staircase_light_switch_controller.sv =====
// Staircase light switch controller: debounce, toggle sequence, auto-off and LED fade.
`timescale 1ns / 1ps

// One request on the input stream is one 5 ms tick carrying the raw button and door
// levels; each request yields exactly one result (load state plus red/green LED drive).
// All per-tick work is a single pass of short logic from the state registers into a
// two-entry output buffer, so a request is taken every clock unless the input stalls,
// and each result is registered into that buffer on acceptance. The input side stalls
// only while both output entries are full. Configuration writes are always accepted and
// take effect on the next tick; write them only while no tick is in flight.
module staircase_light_switch_controller
  import slsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // tick requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] button_pressed, [1] door_closed
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] load_on, [1] red_led, [2] green_led
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    SW_OFF_WAIT_PRESS = 2'd0,
    SW_ON_WAIT_REL    = 2'd1,
    SW_ON_WAIT_PRESS  = 2'd2,
    SW_OFF_WAIT_REL   = 2'd3
  } sw_phase_t;

  typedef enum logic [2:0] {
    FD_IDLE       = 3'd0,
    FD_RED_RISE   = 3'd1,
    FD_RED_ON     = 3'd2,
    FD_RED_FALL   = 3'd3,
    FD_GREEN_RISE = 3'd4,
    FD_GREEN_ON   = 3'd5,
    FD_GREEN_FALL = 3'd6
  } fade_phase_t;

  // configuration
  logic [TICK_W-1:0]  filter_count;
  logic [TICK_W-1:0]  filter_limit;
  logic [TIMER_W-1:0] auto_off_ticks;
  logic [LEVEL_W-1:0] pwm_steps;
  logic               door_enable;

  // tick state
  logic [TICK_W-1:0]  press_ticks, press_ticks_next;
  logic [TICK_W-1:0]  release_ticks, release_ticks_next;
  logic [TICK_W-1:0]  door_closed_ticks, door_closed_ticks_next;
  logic [TICK_W-1:0]  door_open_ticks, door_open_ticks_next;
  sw_phase_t          switch_phase, switch_phase_next;
  logic               light_state, light_state_next;
  logic [TIMER_W-1:0] off_countdown, off_countdown_next;
  logic [LEVEL_W-1:0] pwm_phase, pwm_phase_next;
  logic [LEVEL_W-1:0] red_level, red_level_next;
  logic [LEVEL_W-1:0] green_level, green_level_next;
  fade_phase_t        fade_phase, fade_phase_next;

  // output buffer: main register plus skid entry
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;

  logic                  button, closed;
  logic                  red_on, green_on;
  logic [LEVEL_W:0]      pwm_inc;
  logic [LEVEL_W:0]      red_inc, green_inc;
  logic [OUT_DATA_W-1:0] result;
  logic                  in_accept;

  assign button    = s_axis_tdata[0];
  assign closed    = s_axis_tdata[1];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign cfg_ready     = 1'b1;

  always_comb begin
    press_ticks_next       = press_ticks;
    release_ticks_next     = release_ticks;
    door_closed_ticks_next = door_closed_ticks;
    door_open_ticks_next   = door_open_ticks;
    switch_phase_next      = switch_phase;
    light_state_next       = light_state;
    off_countdown_next     = off_countdown;
    red_level_next         = red_level;
    green_level_next       = green_level;
    fade_phase_next        = fade_phase;
    pwm_inc                = {1'b0, pwm_phase} + 1'b1;
    red_inc                = {1'b0, red_level} + 1'b1;
    green_inc              = {1'b0, green_level} + 1'b1;

    // saturating level counters
    if (door_enable) begin
      if (closed) begin
        if (door_closed_ticks < filter_limit) door_closed_ticks_next = door_closed_ticks + 1'b1;
        door_open_ticks_next = '0;
      end else begin
        if (door_open_ticks < filter_limit) door_open_ticks_next = door_open_ticks + 1'b1;
        door_closed_ticks_next = '0;
      end
    end else begin
      door_closed_ticks_next = '0;
      door_open_ticks_next   = '0;
    end
    if (button) begin
      if (press_ticks < filter_limit) press_ticks_next = press_ticks + 1'b1;
      release_ticks_next = '0;
    end else begin
      if (release_ticks < filter_limit) release_ticks_next = release_ticks + 1'b1;
      press_ticks_next = '0;
    end

    // switch sequence; checks within a phase apply in order
    case (switch_phase)
      SW_OFF_WAIT_PRESS: begin
        if (door_enable && door_open_ticks_next == filter_count) begin
          light_state_next   = 1'b1;
          off_countdown_next = auto_off_ticks;
          switch_phase_next  = SW_ON_WAIT_PRESS;
        end
        if (press_ticks_next == filter_count) begin
          light_state_next   = 1'b1;
          off_countdown_next = auto_off_ticks;
          switch_phase_next  = (switch_phase_next == SW_ON_WAIT_PRESS) ?
                               SW_OFF_WAIT_REL : SW_ON_WAIT_REL;
        end
      end
      SW_ON_WAIT_REL: begin
        if (release_ticks_next == filter_count) switch_phase_next = SW_ON_WAIT_PRESS;
      end
      SW_ON_WAIT_PRESS: begin
        if (auto_off_ticks != '0) begin
          if (off_countdown != '0) begin
            off_countdown_next = off_countdown - 1'b1;
          end else begin
            light_state_next  = 1'b0;
            switch_phase_next = SW_OFF_WAIT_PRESS;
          end
        end
        if (door_enable && door_closed_ticks_next == filter_count) begin
          light_state_next  = 1'b0;
          switch_phase_next = SW_OFF_WAIT_PRESS;
        end
        if (press_ticks_next == filter_count) begin
          light_state_next  = 1'b0;
          // an off earlier in this tick leaves the phase at 0, so the press lands on 1
          switch_phase_next = (switch_phase_next == SW_ON_WAIT_PRESS) ?
                              SW_OFF_WAIT_REL : SW_ON_WAIT_REL;
        end
      end
      SW_OFF_WAIT_REL: begin
        if (release_ticks_next == filter_count) switch_phase_next = SW_OFF_WAIT_PRESS;
      end
      default: begin
        switch_phase_next = SW_OFF_WAIT_PRESS;
      end
    endcase

    // LED drive uses the levels before this tick's fade update
    red_on   = red_level > pwm_phase;
    green_on = green_level > pwm_phase;

    if (pwm_inc >= {1'b0, pwm_steps}) begin
      pwm_phase_next = '0;
      case (fade_phase)
        FD_IDLE: fade_phase_next = light_state_next ? FD_GREEN_RISE : FD_RED_RISE;
        FD_RED_RISE: begin
          if (red_inc >= {1'b0, pwm_steps}) begin
            red_level_next  = pwm_steps;
            fade_phase_next = FD_RED_ON;
          end else begin
            red_level_next = red_inc[LEVEL_W-1:0];
          end
        end
        FD_RED_ON: begin
          if (light_state_next) fade_phase_next = FD_RED_FALL;
        end
        FD_RED_FALL: begin
          if (red_level <= 4'd1) begin
            red_level_next  = '0;
            fade_phase_next = FD_IDLE;
          end else begin
            red_level_next = red_level - 1'b1;
          end
        end
        FD_GREEN_RISE: begin
          if (green_inc >= {1'b0, pwm_steps}) begin
            green_level_next = pwm_steps;
            fade_phase_next  = FD_GREEN_ON;
          end else begin
            green_level_next = green_inc[LEVEL_W-1:0];
          end
        end
        FD_GREEN_ON: begin
          if (!light_state_next) fade_phase_next = FD_GREEN_FALL;
        end
        FD_GREEN_FALL: begin
          if (green_level <= 4'd1) begin
            green_level_next = '0;
            fade_phase_next  = FD_IDLE;
          end else begin
            green_level_next = green_level - 1'b1;
          end
        end
        default: begin
          red_level_next   = '0;
          green_level_next = '0;
          fade_phase_next  = FD_IDLE;
        end
      endcase
    end else begin
      pwm_phase_next = pwm_inc[LEVEL_W-1:0];
    end

    result = {{(OUT_DATA_W-3){1'b0}}, green_on, red_on, light_state_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_count      <= FILTER_COUNT_RST;
      filter_limit      <= FILTER_LIMIT_RST;
      auto_off_ticks    <= AUTO_OFF_TICKS_RST;
      pwm_steps         <= PWM_STEPS_RST;
      door_enable       <= DOOR_ENABLE_RST;
      press_ticks       <= '0;
      release_ticks     <= '0;
      door_closed_ticks <= '0;
      door_open_ticks   <= '0;
      switch_phase      <= SW_OFF_WAIT_PRESS;
      light_state       <= 1'b0;
      off_countdown     <= '0;
      pwm_phase         <= '0;
      red_level         <= '0;
      green_level       <= '0;
      fade_phase        <= FD_IDLE;
      out_valid         <= 1'b0;
      skid_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_FILTER_COUNT:   filter_count   <= cfg_data[TICK_W-1:0];
          REG_FILTER_LIMIT:   filter_limit   <= cfg_data[TICK_W-1:0];
          REG_AUTO_OFF_TICKS: auto_off_ticks <= cfg_data[TIMER_W-1:0];
          REG_PWM_STEPS:      pwm_steps      <= cfg_data[LEVEL_W-1:0];
          REG_DOOR_ENABLE:    door_enable    <= cfg_data[0];
          default: ;
        endcase
      end

      if (in_accept) begin
        press_ticks       <= press_ticks_next;
        release_ticks     <= release_ticks_next;
        door_closed_ticks <= door_closed_ticks_next;
        door_open_ticks   <= door_open_ticks_next;
        switch_phase      <= switch_phase_next;
        light_state       <= light_state_next;
        off_countdown     <= off_countdown_next;
        pwm_phase         <= pwm_phase_next;
        red_level         <= red_level_next;
        green_level       <= green_level_next;
        fade_phase        <= fade_phase_next;
      end

      if (!out_valid || m_axis_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_accept;
          out_data  <= result;
        end
      end else if (in_accept) begin
        skid_valid <= 1'b1;
        skid_data  <= result;
      end
    end
  end

  // the skid entry is only filled behind a held main entry
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid entry filled without an output stall");

  a_request_yields_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_axis_tvalid)
    else $error("accepted tick produced no pending result");

endmodule

// ===== tb/slsc_light_checker.sv =====
// Result checker for the staircase light switch controller: per-tick prediction and compare.
`timescale 1ns / 1ps

module slsc_light_checker
  import slsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] button_pressed, [1] door_closed
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] load_on, [1] red_led, [2] green_led
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic green;
    logic red;
    logic load;
  } light_out_t;

  localparam logic [1:0] SW_OFF_WAIT_PRESS   = 2'd0;
  localparam logic [1:0] SW_ON_WAIT_RELEASE  = 2'd1;
  localparam logic [1:0] SW_ON_WAIT_PRESS    = 2'd2;
  localparam logic [1:0] SW_OFF_WAIT_RELEASE = 2'd3;

  localparam logic [2:0] FADE_IDLE       = 3'd0;
  localparam logic [2:0] FADE_RED_RISE   = 3'd1;
  localparam logic [2:0] FADE_RED_HOLD   = 3'd2;
  localparam logic [2:0] FADE_RED_FALL   = 3'd3;
  localparam logic [2:0] FADE_GREEN_RISE = 3'd4;
  localparam logic [2:0] FADE_GREEN_HOLD = 3'd5;
  localparam logic [2:0] FADE_GREEN_FALL = 3'd6;

  // register copies
  logic [TICK_W-1:0]  flt_count;
  logic [TICK_W-1:0]  flt_limit;
  logic [TIMER_W-1:0] off_delay;
  logic [LEVEL_W-1:0] pwm_steps;
  logic               door_used;

  // controller state
  logic [TICK_W-1:0]  press_t, release_t, door_closed_t, door_open_t;
  logic [1:0]         sw_phase;
  logic               load_state;
  logic [TIMER_W-1:0] countdown;
  logic [LEVEL_W-1:0] pwm_ph, red_lvl, green_lvl;
  logic [2:0]         fade_phase;

  light_out_t expected_outputs[$];
  int         result_no;

  task automatic count_run(input logic active, inout logic [TICK_W-1:0] on_t,
                           inout logic [TICK_W-1:0] off_t);
    if (active) begin
      if (on_t < flt_limit) on_t = on_t + 1'b1;
      off_t = '0;
    end else begin
      if (off_t < flt_limit) off_t = off_t + 1'b1;
      on_t = '0;
    end
  endtask

  task automatic level_up(inout logic [LEVEL_W-1:0] lvl);
    // compare one bit wider so a full-scale level does not wrap
    if ({1'b0, lvl} + 5'd1 >= {1'b0, pwm_steps}) begin
      lvl = pwm_steps;
      fade_phase = fade_phase + 3'd1;
    end else begin
      lvl = lvl + 1'b1;
    end
  endtask

  task automatic level_down(inout logic [LEVEL_W-1:0] lvl);
    if (lvl <= 1) begin
      lvl = '0;
      fade_phase = FADE_IDLE;
    end else begin
      lvl = lvl - 1'b1;
    end
  endtask

  task automatic predict_tick(input logic btn, input logic closed, output light_out_t res);
    if (door_used) begin
      count_run(closed, door_closed_t, door_open_t);
    end else begin
      door_closed_t = '0;
      door_open_t = '0;
    end
    count_run(btn, press_t, release_t);

    case (sw_phase)
      SW_OFF_WAIT_PRESS: begin
        // door open and press can both fire here: +2 then +1
        if (door_used && door_open_t == flt_count) begin
          load_state = 1'b1;
          countdown = off_delay;
          sw_phase = sw_phase + 2'd2;
        end
        if (press_t == flt_count) begin
          load_state = 1'b1;
          countdown = off_delay;
          sw_phase = sw_phase + 2'd1;
        end
      end
      SW_ON_WAIT_RELEASE: begin
        if (release_t == flt_count) sw_phase = SW_ON_WAIT_PRESS;
      end
      SW_ON_WAIT_PRESS: begin
        if (off_delay != 0) begin
          if (countdown > 0) begin
            countdown = countdown - 1'b1;
          end else begin
            load_state = 1'b0;
            sw_phase = SW_OFF_WAIT_PRESS;
          end
        end
        if (door_used && door_closed_t == flt_count) begin
          load_state = 1'b0;
          sw_phase = SW_OFF_WAIT_PRESS;
        end
        // a press after an off in the same tick lands in the wait-release phase, load off
        if (press_t == flt_count) begin
          load_state = 1'b0;
          sw_phase = sw_phase + 2'd1;
        end
      end
      SW_OFF_WAIT_RELEASE: begin
        if (release_t == flt_count) sw_phase = SW_OFF_WAIT_PRESS;
      end
      default: ;
    endcase

    res.load = load_state;
    res.red = red_lvl > pwm_ph;
    res.green = green_lvl > pwm_ph;

    pwm_ph = pwm_ph + 1'b1;
    if (pwm_ph >= pwm_steps) begin
      pwm_ph = '0;
      case (fade_phase)
        FADE_IDLE:       fade_phase = load_state ? FADE_GREEN_RISE : FADE_RED_RISE;
        FADE_RED_RISE:   level_up(red_lvl);
        FADE_RED_HOLD:   if (load_state) fade_phase = FADE_RED_FALL;
        FADE_RED_FALL:   level_down(red_lvl);
        FADE_GREEN_RISE: level_up(green_lvl);
        FADE_GREEN_HOLD: if (!load_state) fade_phase = FADE_GREEN_FALL;
        FADE_GREEN_FALL: level_down(green_lvl);
        default: begin
          red_lvl = '0;
          green_lvl = '0;
          fade_phase = FADE_IDLE;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    light_out_t got;
    light_out_t want;
    if (rst) begin
      flt_count = FILTER_COUNT_RST;
      flt_limit = FILTER_LIMIT_RST;
      off_delay = AUTO_OFF_TICKS_RST;
      pwm_steps = PWM_STEPS_RST;
      door_used = DOOR_ENABLE_RST;
      press_t = '0;
      release_t = '0;
      door_closed_t = '0;
      door_open_t = '0;
      sw_phase = SW_OFF_WAIT_PRESS;
      load_state = 1'b0;
      countdown = '0;
      pwm_ph = '0;
      red_lvl = '0;
      green_lvl = '0;
      fade_phase = FADE_IDLE;
      expected_outputs.delete();
      result_no = 0;
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILTER_COUNT:   flt_count = cfg_data[TICK_W-1:0];
          REG_FILTER_LIMIT:   flt_limit = cfg_data[TICK_W-1:0];
          REG_AUTO_OFF_TICKS: off_delay = cfg_data[TIMER_W-1:0];
          REG_PWM_STEPS:      pwm_steps = cfg_data[LEVEL_W-1:0];
          REG_DOOR_ENABLE:    door_used = cfg_data[0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[2:0];
        if (expected_outputs.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with no request pending: load %b red %b green %b",
                     result_no, got.load, got.red, got.green);
          mismatches++;
        end else begin
          want = expected_outputs.pop_front();
          if (got.load !== want.load || got.red !== want.red || got.green !== want.green) begin
            if (mismatches < 10)
              $display("result %0d: expected load %b red %b green %b, got load %b red %b green %b",
                       result_no, want.load, want.red, want.green,
                       got.load, got.red, got.green);
            mismatches++;
          end
        end
        result_no++;
      end

      if (s_axis_tvalid && s_axis_tready) begin
        predict_tick(s_axis_tdata[0], s_axis_tdata[1], want);
        expected_outputs.push_back(want);
      end

      outstanding = expected_outputs.size();
    end
  end

endmodule

// ===== tb/tb_staircase_light_switch_controller.sv =====
// Testbench top for the staircase light switch controller: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_staircase_light_switch_controller;
  import slsc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  wire                   s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic calm = 1'b0;         // no idling on either side while set
  logic stall_req = 1'b0;
  logic stall_taken = 1'b0;
  int   stall_left = 0;
  int   fc_now = int'(FILTER_COUNT_RST);
  int   mismatches;
  int   outstanding;

  staircase_light_switch_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  slsc_light_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_req && !stall_taken) begin
      stall_taken <= 1'b1;
      stall_left <= 60;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 16);
    end
  end

  task automatic send_tick(input logic btn, input logic door);
    while (!calm && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_DATA_W-2){1'b0}}, door, btn};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] fc, input logic [7:0] fl,
                          input logic [15:0] off_ticks, input logic [3:0] steps,
                          input logic door_en);
    write_reg(REG_FILTER_COUNT, {8'd0, fc});
    write_reg(REG_FILTER_LIMIT, {8'd0, fl});
    write_reg(REG_AUTO_OFF_TICKS, off_ticks);
    write_reg(REG_PWM_STEPS, {12'd0, steps});
    write_reg(REG_DOOR_ENABLE, {15'd0, door_en});
    cfg_valid <= 1'b0;
    fc_now = int'(fc);
  endtask

  // wait until every tick request has its result, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly runs just long enough to pass the filter; some short glitches, some long holds
  function automatic int run_length(input int base, input int slack);
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 15)
      len = $urandom_range((base > 1) ? base - 1 : 1, 1);
    else if (pick < 30)
      len = base + $urandom_range(slack * 4, slack);
    else
      len = base + $urandom_range(slack, 0);
    if (len < 1) len = 1;
    return len;
  endfunction

  task automatic run_random(input int n_items);
    int   btn_left;
    int   door_left;
    logic btn;
    logic door;
    btn_left = 0;
    door_left = 0;
    btn = 1'($urandom_range(1, 0));
    door = 1'($urandom_range(1, 0));
    for (int k = 0; k < n_items; k++) begin
      if (btn_left <= 0) begin
        btn = ~btn;
        btn_left = run_length(fc_now, 3);
      end
      if (door_left <= 0) begin
        door = ~door;
        door_left = run_length(fc_now, 12);
      end
      send_tick(btn, door);
      btn_left--;
      door_left--;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // defaults: door open and press reach the filter on the same tick, then close and release
    repeat (12) send_tick(1'b1, 1'b0);
    repeat (12) send_tick(1'b0, 1'b1);
    drain();

    set_regs(8'd2, 8'd4, 16'd20, 4'd3, 1'b1);
    calm <= 1'b1;
    run_random(100);
    calm <= 1'b0;
    run_random(200);
    drain();

    // one-tick filter, no auto-off, door ignored
    set_regs(8'd1, 8'd1, 16'd0, 4'd1, 1'b0);
    run_random(200);
    drain();

    set_regs(8'd255, 8'd255, 16'd65535, 4'd15, 1'b1);
    run_random(260);
    drain();

    // filter above limit never fires; zero PWM steps
    set_regs(8'd5, 8'd3, 16'd1, 4'd0, 1'b1);
    run_random(150);
    drain();

    // zero filter matches every tick, so off and press coincide
    set_regs(8'd0, 8'd0, 16'd3, 4'd2, 1'b1);
    run_random(150);
    drain();

    set_regs(8'd3, 8'd10, 16'd7, 4'd4, 1'b1);
    run_random(60);
    stall_req <= 1'b1;
    run_random(210);
    drain();

    if (mismatches == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/slsc_pkg.sv
hdl/staircase_light_switch_controller.sv
tb/slsc_light_checker.sv
tb/tb_staircase_light_switch_controller.sv
